>>> rtl/core/gb8_pkg.sv
// Package for the 8x8 glyph blitter: word layouts, function codes, sequencer
// states and parameter defaults. Depends on nothing; gb8_if and the top level use it.
`timescale 1ns / 1ps

package gb8_pkg;

    // Parameter defaults for the top level
    localparam int GLYPH_ROWS_DEF  = 8;
    localparam int LINE_PITCH_DEF  = 320;
    localparam int GLYPH_COUNT_DEF = 256;

    // Fixed by the row bitmap width, and the pixel word field widths
    localparam int GLYPH_COLS = 8;
    localparam int COL_W      = 3;
    localparam int ADDR_W     = 16;
    localparam int PIXEL_W    = 8;

    // Function codes of a command word
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    // Command word
    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
        logic [2:0] glyph_row;
        logic [7:0] row_bits;
        logic [8:0] x_pos;
        logic [7:0] y_pos;
        logic [7:0] color;
        logic       transparent;
    } cmd_word_t;

    // Pixel word
    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [PIXEL_W-1:0] pixel_value;
        logic               write_enable;
        logic               last_pixel;
    } pix_word_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_DRAW
    } blit_state_t;

endpackage

>>> rtl/core/gb8_if.sv
// Valid/ready channel interfaces for the glyph blitter command and pixel words.
// Depends on gb8_pkg for the word layouts.
`timescale 1ns / 1ps

interface gb8_cmd_if;
    logic                  valid;
    logic                  ready;
    gb8_pkg::cmd_word_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gb8_pix_if;
    logic                  valid;
    logic                  ready;
    gb8_pkg::pix_word_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/gb8_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered,
// enabled read data. No package dependency.
`timescale 1ns / 1ps

module gb8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read word; the read word holds between reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/glyph_blitter_8x8.sv
// Glyph blitter top level: font store, draw sequencer and pixel output register.
// Depends on gb8_pkg, gb8_if and gb8_ram.
//
// A load word writes one row bitmap of one glyph into the font store. A draw
// word produces GLYPH_ROWS*8 pixel words, one per cycle while the pixel channel
// takes them, row by row, leftmost pixel first; the next command word is taken
// the cycle after the last pixel is generated. The pace is one font store read
// per glyph row, fetched during the last pixel of the previous row, and one
// pixel through the output register per cycle while the pixel channel takes
// them. Addresses are (y_pos+row)*LINE_PITCH + x_pos + column, wrapping at 16
// bits, with no clipping. The font store is not cleared at reset: drawing a
// glyph row never loaded gives undefined pixel values.
`timescale 1ns / 1ps

module glyph_blitter_8x8 #(
    parameter int GLYPH_ROWS  = gb8_pkg::GLYPH_ROWS_DEF,
    parameter int LINE_PITCH  = gb8_pkg::LINE_PITCH_DEF,
    parameter int GLYPH_COUNT = gb8_pkg::GLYPH_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    gb8_cmd_if.sink       cmd,
    gb8_pix_if.source     pix
);

    localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
    localparam int CW    = gb8_pkg::COL_W;
    localparam int PW    = gb8_pkg::ADDR_W;
    localparam logic [RW-1:0] LAST_ROW = RW'(GLYPH_ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(gb8_pkg::GLYPH_COLS - 1);
    // Step from the last pixel of a row to the first of the next, modulo 2^16
    localparam logic [PW-1:0] ROW_STEP =
        PW'(LINE_PITCH + 65536 - (gb8_pkg::GLYPH_COLS - 1));

    gb8_pkg::blit_state_t state_reg, state_next;

    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [PW-1:0]  addr_reg, addr_next;
    logic [AW-1:0]  rd_addr_reg, rd_addr_next;
    logic           code_ok_reg, code_ok_next;
    logic           trans_reg, trans_next;
    logic [7:0]     color_reg, color_next;

    logic                 out_valid_reg, out_valid_next;
    gb8_pkg::pix_word_t   out_word_reg, out_word_next;

    logic           cmd_fire;
    logic           draw_start;
    logic           code_in_range;
    logic           row_in_range;
    logic           ram_wr_en;
    logic [AW-1:0]  ram_wr_addr;
    logic           ram_rd_en;
    logic [AW-1:0]  ram_rd_addr;
    logic [7:0]     ram_rd_data;
    logic [AW-1:0]  glyph_base;
    logic           gen_fire;
    logic           gen_last_col;
    logic           gen_last;
    logic           glyph_bit;

    // Font store
    gb8_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_font_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (cmd.data.row_bits),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Decode the command word
    assign cmd.ready     = (state_reg == gb8_pkg::ST_IDLE);
    assign cmd_fire      = cmd.valid && cmd.ready;
    assign draw_start    = cmd_fire && (cmd.data.func == gb8_pkg::FUNC_DRAW);
    assign code_in_range = (9'(cmd.data.char_code) < 9'(GLYPH_COUNT));
    assign row_in_range  = (5'(cmd.data.glyph_row) < 5'(GLYPH_ROWS));
    assign glyph_base    = AW'(32'(cmd.data.char_code) * GLYPH_ROWS);

    // Load: write one row, dropping rows and codes beyond the store
    assign ram_wr_en   = cmd_fire && (cmd.data.func == gb8_pkg::FUNC_LOAD)
                         && code_in_range && row_in_range;
    assign ram_wr_addr = AW'(32'(glyph_base) + 32'(cmd.data.glyph_row));

    // Pixel generation
    assign gen_fire     = (state_reg == gb8_pkg::ST_DRAW)
                          && (!out_valid_reg || pix.ready);
    assign gen_last_col = (col_reg == LAST_COL);
    assign gen_last     = gen_last_col && (row_reg == LAST_ROW);
    assign glyph_bit    = ram_rd_data[~col_reg] && code_ok_reg;

    // Fetch row 0 on draw start, the next row during the last pixel of a row
    assign ram_rd_en   = draw_start || (gen_fire && gen_last_col && !gen_last);
    assign ram_rd_addr = draw_start ? (code_in_range ? glyph_base : '0)
                                    : rd_addr_reg + AW'(1);

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        addr_next    = addr_reg;
        rd_addr_next = rd_addr_reg;
        code_ok_next = code_ok_reg;
        trans_next   = trans_reg;
        color_next   = color_reg;

        if (ram_rd_en)
        begin
            rd_addr_next = ram_rd_addr;
        end

        unique case (state_reg)
            gb8_pkg::ST_IDLE:
            begin
                if (draw_start)
                begin
                    state_next   = gb8_pkg::ST_DRAW;
                    col_next     = '0;
                    row_next     = '0;
                    addr_next    = PW'(32'(cmd.data.y_pos) * LINE_PITCH
                                       + 32'(cmd.data.x_pos));
                    code_ok_next = code_in_range;
                    trans_next   = cmd.data.transparent;
                    color_next   = cmd.data.color;
                end
            end
            gb8_pkg::ST_DRAW:
            begin
                if (gen_fire)
                begin
                    if (gen_last)
                    begin
                        state_next = gb8_pkg::ST_IDLE;
                    end
                    if (gen_last_col)
                    begin
                        col_next  = '0;
                        row_next  = row_reg + RW'(1);
                        addr_next = addr_reg + ROW_STEP;
                    end
                    else
                    begin
                        col_next  = col_reg + CW'(1);
                        addr_next = addr_reg + PW'(1);
                    end
                end
            end
            default:
            begin
                state_next = gb8_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register: load on generation, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !pix.ready;
        out_word_next  = out_word_reg;
        if (gen_fire)
        begin
            out_valid_next              = 1'b1;
            out_word_next.pixel_address = addr_reg;
            out_word_next.pixel_value   = glyph_bit ? color_reg : 8'd0;
            out_word_next.write_enable  = glyph_bit || !trans_reg;
            out_word_next.last_pixel    = gen_last;
        end
    end

    assign pix.valid = out_valid_reg;
    assign pix.data  = out_word_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gb8_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        row_reg      <= row_next;
        addr_reg     <= addr_next;
        rd_addr_reg  <= rd_addr_next;
        code_ok_reg  <= code_ok_next;
        trans_reg    <= trans_next;
        color_reg    <= color_next;
        out_word_reg <= out_word_next;
    end

    // The store is never written while a glyph is being drawn
    a_no_write_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gb8_pkg::ST_DRAW) |-> !ram_wr_en)
        else $error("font store written during a draw");

    // The last pixel ends the draw
    a_last_ends_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (gen_fire && gen_last) |=> (state_reg == gb8_pkg::ST_IDLE))
        else $error("draw did not end after the last pixel");

    // An opaque draw writes every pixel
    a_opaque_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (gen_fire && !trans_reg) |=> pix.data.write_enable)
        else $error("opaque pixel marked as no write");

    // A skipped pixel carries a zero value
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && !pix.data.write_enable) |-> (pix.data.pixel_value == 8'd0))
        else $error("skipped pixel with non-zero value");

endmodule
